@@ sv/secded_pkg.sv @@
// Shared types, constants and bit-mapping functions for the SECDED Hamming codec.
package secded_pkg;

	localparam int WORD_W = 64;
	localparam int ORDER_W = 3;
	localparam int SYN_W = 6;
	localparam int FIRST_DATA_POS = 3;

	localparam logic [ORDER_W-1:0] MIN_ORDER = 3'd2;
	localparam logic [ORDER_W-1:0] MAX_ORDER = 3'd6;
	localparam logic [ORDER_W-1:0] RESET_ORDER = 3'd6;

	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_FIXED = 2'd1;
	localparam logic [1:0] STATUS_BAD = 2'd2;

	typedef struct packed {
		logic op;
		logic [WORD_W-1:0] word_in;
	} in_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] word_out;
		logic [1:0] status;
	} out_item_t;

	function automatic logic [WORD_W-1:0] len_mask(input logic [ORDER_W-1:0] order);
		logic [WORD_W-1:0] m;
		m = '0;
		for (int i = 0; i < WORD_W; i++) begin
			m[i] = (i < (1 << order));
		end
		return m;
	endfunction

	// scatter data bits onto the non-power-of-two positions from 3 upward
	function automatic logic [WORD_W-1:0] expand(input logic [WORD_W-1:0] d);
		logic [WORD_W-1:0] r;
		int k;
		r = '0;
		k = 0;
		for (int p = FIRST_DATA_POS; p < WORD_W; p++) begin
			if ((p & (p - 1)) != 0) begin
				r[p] = d[k];
				k++;
			end
		end
		return r;
	endfunction

	// gather the data positions back into the low bits
	function automatic logic [WORD_W-1:0] compress(input logic [WORD_W-1:0] cw);
		logic [WORD_W-1:0] r;
		int k;
		r = '0;
		k = 0;
		for (int p = FIRST_DATA_POS; p < WORD_W; p++) begin
			if ((p & (p - 1)) != 0) begin
				r[k] = cw[p];
				k++;
			end
		end
		return r;
	endfunction

	function automatic logic [SYN_W-1:0] syndrome(input logic [WORD_W-1:0] cw);
		logic [SYN_W-1:0] s;
		s = '0;
		for (int p = 0; p < WORD_W; p++) begin
			if (cw[p]) begin
				s = s ^ SYN_W'(p);
			end
		end
		return s;
	endfunction

endpackage

@@ sv/secded_hamming_codec.sv @@
// Top level of the SECDED Hamming codec: input register, codec logic, result register.
// Extended Hamming SECDED encoder and decoder over a codeword of 2^order bits, order set
// by the configuration write (values below 2 act as 2, above 6 as 6). Each item passes
// an input register, one level of XOR-tree logic and a result register: a result is
// offered from the result register; one item is taken every cycle while not stalled.
// Write the order only while the block holds no items.
module secded_hamming_codec (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  secded_pkg::in_item_t   in_item,
	output logic                   out_valid,
	input  logic                   out_ready,
	output secded_pkg::out_item_t  out_item,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [2:0]             cfg_data
);
	import secded_pkg::*;

	logic [ORDER_W-1:0] order_q;
	logic v_s1;
	logic op_s1;
	logic [WORD_W-1:0] word_s1;
	logic v_s2;
	out_item_t res_s2;

	logic adv_s1;
	logic [WORD_W-1:0] mask;
	logic [WORD_W-1:0] cw;
	logic [WORD_W-1:0] data_cw;
	logic [WORD_W-1:0] enc_cw;
	logic [WORD_W-1:0] fixed_cw;
	logic [SYN_W-1:0] syn;
	logic par;
	logic err;
	out_item_t res;

	assign cfg_ready = 1'b1;
	assign adv_s1 = !v_s2 || out_ready;
	assign in_ready = !v_s1 || adv_s1;
	assign out_valid = v_s2;
	assign out_item = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= RESET_ORDER;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_data < MIN_ORDER) begin
				order_q <= MIN_ORDER;
			end else if (cfg_data > MAX_ORDER) begin
				order_q <= MAX_ORDER;
			end else begin
				order_q <= cfg_data;
			end
		end
	end

	always_comb begin
		mask = len_mask(order_q);
		data_cw = expand(word_s1) & mask;
		enc_cw = data_cw;
		syn = syndrome(data_cw);
		for (int i = 0; i < SYN_W; i++) begin
			enc_cw[1 << i] = syn[i];
		end
		enc_cw[0] = ^enc_cw[WORD_W-1:1];

		cw = word_s1 & mask;
		par = ^cw;
		err = (syndrome(cw) != '0) || par;
		fixed_cw = cw;
		if (err) begin
			fixed_cw[syndrome(cw)] = !cw[syndrome(cw)];
		end

		if (op_s1 == OP_ENCODE) begin
			res.word_out = enc_cw;
			res.status = STATUS_OK;
		end else begin
			res.word_out = compress(fixed_cw);
			if (!err) begin
				res.status = STATUS_OK;
			end else if (par) begin
				res.status = STATUS_FIXED;
			end else begin
				res.status = STATUS_BAD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (adv_s1) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1 <= in_item.op;
			word_s1 <= in_item.word_in;
		end
		if (v_s1 && adv_s1) begin
			res_s2 <= res;
		end
	end

`ifndef SYNTHESIS
	a_order_range: assert property (@(posedge clk) disable iff (!arst_n)
		order_q >= MIN_ORDER && order_q <= MAX_ORDER)
		else $error("order register out of range");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.status == STATUS_OK || out_item.status == STATUS_FIXED ||
			out_item.status == STATUS_BAD))
		else $error("undefined status code");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted item lost from input stage");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv_s1) |=> (v_s1 && $stable(word_s1) && $stable(op_s1)))
		else $error("stalled input stage changed");
`endif

endmodule
